// ===== hdl/btkvl_pkg.sv =====
`timescale 1ns / 1ps

package btkvl_pkg;

  localparam int CAPACITY    = 128;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int WEIGHT_W    = 48;
  localparam int SIZE_W      = 40;
  localparam int ID_W        = 16;
  localparam int COUNT_OUT_W = 8;
  localparam int OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  // weight sits in the lowest bits, id in the highest
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [SIZE_W-1:0]   size;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  localparam int IN_DATA_W  = $bits(entry_t);
  localparam int OUT_DATA_W = $bits(entry_t) + COUNT_OUT_W;
  localparam int OUT_USER_W = 2;

  typedef enum logic [2:0] {
    RD_TOP,     // count - 1
    RD_BASE,    // entry 0
    RD_BELOW,   // ptr - 2
    RD_ABOVE,   // ptr + 1
    RD_ABOVE2   // ptr + 2
  } rd_sel_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_DEC,
    PTR_INC
  } ptr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic {
    WR_NEW,
    WR_RD
  } wr_src_t;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_src_t wr_src;
    ptr_op_t ptr_op;
    cnt_op_t cnt_op;
    logic    res_clear;
    logic    res_pop;
    logic    res_acc_set;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic rd_lt;
    logic ptr_is_one;
    logic ptr_p1_top;
    logic ptr_p2_top;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/btkvl_dpath.sv =====
`timescale 1ns / 1ps

module btkvl_dpath
  import btkvl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  entry_t                in_entry,
  input  dp_cmd_t               cmd,
  input  logic                  m_tready,
  output dp_status_t            status,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser
);

  entry_t            mem [CAPACITY];
  entry_t            new_entry;
  entry_t            rd_data;
  entry_t            res_entry;
  entry_t            wr_data;
  logic              res_valid;
  logic              res_acc;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W:0]    ptr_p1;
  logic [CNT_W:0]    ptr_p2;

  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:    rd_idx = count - CNT_W'(1);
      RD_BASE:   rd_idx = '0;
      RD_BELOW:  rd_idx = ptr - CNT_W'(2);
      RD_ABOVE:  rd_idx = ptr + CNT_W'(1);
      RD_ABOVE2: rd_idx = ptr + CNT_W'(2);
      default:   rd_idx = '0;
    endcase
  end

  assign rd_addr = rd_idx[ADDR_W-1:0];
  assign wr_data = (cmd.wr_src == WR_NEW) ? new_entry : rd_data;

  // Entry store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[ptr[ADDR_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      new_entry <= in_entry;
    end
    case (cmd.ptr_op)
      PTR_ZERO:  ptr <= '0;
      PTR_COUNT: ptr <= count;
      PTR_DEC:   ptr <= ptr - CNT_W'(1);
      PTR_INC:   ptr <= ptr + CNT_W'(1);
      default:   ptr <= ptr;
    endcase
    if (cmd.res_clear) begin
      res_valid <= 1'b0;
      res_acc   <= 1'b0;
      res_entry <= '0;
    end else begin
      if (cmd.res_pop) begin
        res_valid <= 1'b1;
        res_entry <= rd_data;
      end
      if (cmd.res_acc_set) begin
        res_acc <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      m_tdata <= {COUNT_OUT_W'(count), res_entry};
      m_tuser <= {res_acc, res_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: count <= count + CNT_W'(1);
        CNT_DEC: count <= count - CNT_W'(1);
        CNT_CLR: count <= '0;
        default: count <= count;
      endcase
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign ptr_p1 = {1'b0, ptr} + (CNT_W+1)'(1);
  assign ptr_p2 = {1'b0, ptr} + (CNT_W+1)'(2);

  assign status.empty      = (count == '0);
  assign status.full       = (count == CNT_W'(CAPACITY));
  assign status.rd_lt      = (rd_data.weight < new_entry.weight);
  assign status.ptr_is_one = (ptr == CNT_W'(1));
  assign status.ptr_p1_top = (ptr_p1 == (CNT_W+1)'(CAPACITY));
  assign status.ptr_p2_top = (ptr_p2 == (CNT_W+1)'(CAPACITY));
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

// ===== hdl/btkvl_ctrl.sv =====
`timescale 1ns / 1ps

module btkvl_ctrl
  import btkvl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  opcode_t    in_op,
  input  dp_status_t status,
  output logic       s_tready,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SHIFT_UP,
    ST_CHK_LOW,
    ST_SHIFT_DN,
    ST_PLACE,
    ST_POP_WAIT,
    ST_FINISH
  } state_t;

  state_t  state;
  state_t  state_next;
  opcode_t op;
  logic    grow;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_TOP;
    cmd.wr_src = WR_NEW;
    cmd.ptr_op = PTR_HOLD;
    cmd.cnt_op = CNT_HOLD;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.res_clear = 1'b1;
        state_next    = ST_FINISH;
        case (op)
          OP_INSERT: begin
            if (status.empty) begin
              cmd.ptr_op = PTR_ZERO;
              state_next = ST_PLACE;
            end else if (!status.full) begin
              cmd.ptr_op = PTR_COUNT;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TOP;
              state_next = ST_SHIFT_UP;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_BASE;
              state_next = ST_CHK_LOW;
            end
          end
          OP_POP: begin
            if (!status.empty) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TOP;
              state_next = ST_POP_WAIT;
            end
          end
          OP_CLEAR: cmd.cnt_op = CNT_CLR;
          default:  cmd.cnt_op = CNT_HOLD;
        endcase
      end
      ST_SHIFT_UP: begin
        // move larger-or-equal entries up one slot
        cmd.wr_en = 1'b1;
        if (!status.rd_lt) begin
          cmd.wr_src = WR_RD;
          cmd.ptr_op = PTR_DEC;
          if (status.ptr_is_one) begin
            state_next = ST_PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_BELOW;
          end
        end else begin
          cmd.cnt_op      = CNT_INC;
          cmd.res_acc_set = 1'b1;
          state_next      = ST_FINISH;
        end
      end
      ST_CHK_LOW: begin
        // full list: reject unless the new weight beats the smallest
        if (!status.rd_lt) begin
          state_next = ST_FINISH;
        end else if (status.ptr_p1_top) begin
          state_next = ST_PLACE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ABOVE;
          state_next = ST_SHIFT_DN;
        end
      end
      ST_SHIFT_DN: begin
        // drop the smallest, move smaller entries down one slot
        cmd.wr_en = 1'b1;
        if (status.rd_lt) begin
          cmd.wr_src = WR_RD;
          cmd.ptr_op = PTR_INC;
          if (status.ptr_p2_top) begin
            state_next = ST_PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ABOVE2;
          end
        end else begin
          cmd.res_acc_set = 1'b1;
          state_next      = ST_FINISH;
        end
      end
      ST_PLACE: begin
        cmd.wr_en       = 1'b1;
        cmd.cnt_op      = grow ? CNT_INC : CNT_HOLD;
        cmd.res_acc_set = 1'b1;
        state_next      = ST_FINISH;
      end
      ST_POP_WAIT: begin
        cmd.res_pop = 1'b1;
        cmd.cnt_op  = CNT_DEC;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_NOP;
      grow  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_in) begin
        op <= in_op;
      end
      if (state == ST_DISPATCH) begin
        grow <= !status.full;
      end
    end
  end

endmodule

// ===== hdl/bounded_topk_victim_list.sv =====
`timescale 1ns / 1ps

// Bounded top-k victim list: up to CAPACITY entries kept sorted by ascending
// weight in a single-port-write, registered-read entry store.
// Slave channel: one request per handshake. s_tuser carries the opcode
// (insert, pop largest, clear, no-op); s_tdata carries the entry.
// Master channel: exactly one result per request, holding the popped entry,
// the pop and insert-stored flags, and the entry count after the request.
// A clear, a no-op or a pop from an empty list goes from dispatch to the
// finish state, which loads the result register; a pop first reads the top
// entry. An insert walks the store one entry per cycle, moving larger
// entries up one slot, or, when the list is full and the smallest is
// dropped, smaller entries down one slot; a rejected insert moves nothing.
// At most CAPACITY - 1 entries move, each through the single read port.
// Requests are taken one at a time: s_tready is high only while the
// controller is idle, from the cycle after the result is loaded.
// Reset clears the entry count and m_tvalid; the stored entries are not
// cleared, nothing beyond the count is ever read.
// When the receiver stalls, the finished result waits in the output
// register and the controller holds until it is taken.
module bounded_topk_victim_list
  import btkvl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: weight[47:0], file_size[87:48], entry_id[103:88]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: opcode[1:0]
  input  logic [OP_W-1:0]       s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: out_weight[47:0], out_size[87:48], out_id[103:88],
  //          entry_count[111:104]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: result_valid[0], accepted[1]
  output logic [OUT_USER_W-1:0] m_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;
  entry_t     in_entry;
  opcode_t    in_op;

  assign in_entry = entry_t'(s_tdata);
  assign in_op    = opcode_t'(s_tuser);

  btkvl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_op    (in_op),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  btkvl_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_entry (in_entry),
    .cmd      (cmd),
    .m_tready (m_tready),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A pop never also stores an entry
  a_pop_not_insert: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result flags pop and insert together");

  // The reported count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_DATA_W-1 -: COUNT_OUT_W] <= COUNT_OUT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

  // Without a popped entry the entry fields read zero
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[IN_DATA_W-1:0] == '0))
    else $error("entry fields set without a pop");

  // One request at a time: ready drops right after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while busy");

endmodule
